// ----- design/tdr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and constants of the trie dictionary rewriter: item
// structs, item kinds, cell entry layout and memory control bundle.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int unsigned DEF_CELL_DEPTH    = 65536;
  localparam int unsigned DEF_INFO_DEPTH    = 65536;
  localparam int unsigned DEF_ALPHABET_SIZE = 256;
  localparam int unsigned DEF_MAX_INFO_LEN  = 63;

  // Width for range compares: holds the largest depth and any 17-bit sum
  localparam int unsigned CMP_W = 25;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_ALPHA  = 2'd1,
    KIND_CELL   = 2'd2,
    KIND_INFO   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] symbol;
    logic [15:0] load_address;
    logic [15:0] load_value;
    logic [7:0]  load_check;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_symbol;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] target;
    logic [7:0]  check;
  } cell_entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ----- design/tdr_alpha_map.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_alpha_map
// Symbol to letter code map: single-port memory with one valid bit per
// entry, so that an entry never written reads as code zero.
// ----------------------------------------------------------------------------
module tdr_alpha_map #(
  parameter int unsigned ALPHABET_SIZE = tdr_pkg::DEF_ALPHABET_SIZE
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tdr_pkg::mem_ctl_t                ctl,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] addr,
  input  wire logic [7:0]                       wr_code,
  output logic [7:0]                            rd_code
);
  import tdr_pkg::*;

  logic [7:0]               mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [7:0]               rd_code_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_code;
    end
    if (ctl.rd_en) begin
      rd_code_r <= valid_r[addr] ? mem[addr] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[addr] <= 1'b1;
    end
  end

  assign rd_code = rd_code_r;

endmodule
`default_nettype wire

// ----- design/tdr_cell_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_cell_table
// Double-array trie cells (target, check): single-port memory, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module tdr_cell_table #(
  parameter int unsigned CELL_DEPTH = tdr_pkg::DEF_CELL_DEPTH
) (
  input  wire logic                          clk,
  input  wire tdr_pkg::mem_ctl_t             ctl,
  input  wire logic [$clog2(CELL_DEPTH)-1:0] addr,
  input  wire tdr_pkg::cell_entry_t          wr_entry,
  output tdr_pkg::cell_entry_t               rd_entry
);
  import tdr_pkg::*;

  cell_entry_t mem [CELL_DEPTH];
  cell_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry_r <= mem[addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule
`default_nettype wire

// ----- design/tdr_info_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_info_store
// Info word store: single-port memory of 16-bit words, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module tdr_info_store #(
  parameter int unsigned INFO_DEPTH = tdr_pkg::DEF_INFO_DEPTH
) (
  input  wire logic                          clk,
  input  wire tdr_pkg::mem_ctl_t             ctl,
  input  wire logic [$clog2(INFO_DEPTH)-1:0] addr,
  input  wire logic [15:0]                   wr_word,
  output logic [15:0]                        rd_word
);
  import tdr_pkg::*;

  logic [15:0] mem [INFO_DEPTH];
  logic [15:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[addr];
    end
  end

  assign rd_word = rd_word_r;

endmodule
`default_nettype wire

// ----- design/trie_dictionary_rewriter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trie_dictionary_rewriter_core
// Double-array trie matcher over a 16-bit symbol stream: echoes each
// symbol and, on reaching a final cell, emits that cell's info string.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_ready   | in_item_t  (kind, symbol, load_*)
//  out_     | output    | out_valid/out_ready | out_item_t (out_symbol, last)
//
// A load item is handled while idle. A symbol item runs chained reads
// (alphabet, cell at state plus code, cell at new state, first info
// word), one more per info word emitted and one to find the terminating
// zero word, then posts the last result; it runs fewer reads when the walk
// ends early or the string is cut at the length limit.
// Reset clears all alphabet valid bits together; there is no clearing pass.
// The output register lets the next item in while the last result waits;
// a stalled output holds the info walk in place.
// ----------------------------------------------------------------------------
module trie_dictionary_rewriter_core #(
  parameter int unsigned CELL_DEPTH    = tdr_pkg::DEF_CELL_DEPTH,
  parameter int unsigned INFO_DEPTH    = tdr_pkg::DEF_INFO_DEPTH,
  parameter int unsigned ALPHABET_SIZE = tdr_pkg::DEF_ALPHABET_SIZE,
  parameter int unsigned MAX_INFO_LEN  = tdr_pkg::DEF_MAX_INFO_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tdr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tdr_pkg::out_item_t     out_data
);
  import tdr_pkg::*;

  localparam int unsigned CAW  = $clog2(CELL_DEPTH);
  localparam int unsigned IAW  = $clog2(INFO_DEPTH);
  localparam int unsigned ALW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned CNTW = $clog2(MAX_INFO_LEN + 1);

  localparam logic [CMP_W-1:0] CELL_LIM  = CMP_W'(CELL_DEPTH);
  localparam logic [CMP_W-1:0] INFO_LIM  = CMP_W'(INFO_DEPTH);
  localparam logic [CMP_W-1:0] ALPHA_LIM = CMP_W'(ALPHABET_SIZE);
  localparam logic [CNTW-1:0]  LEN_LIM   = CNTW'(MAX_INFO_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE,
    S_STEP,
    S_FINAL,
    S_INFO,
    S_END
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     cur_r, cur_nxt;
  logic [15:0]     root_r, root_nxt;
  logic [15:0]     hold_r, hold_nxt;
  logic [7:0]      code_r, code_nxt;
  logic            code_ok_r, code_ok_nxt;
  logic [15:0]     base_r, base_nxt;
  logic [CNTW-1:0] n_r, n_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  mem_ctl_t        alpha_ctl, cell_ctl, info_ctl;
  logic [ALW-1:0]  alpha_addr;
  logic [7:0]      alpha_code;
  logic [CAW-1:0]  cell_addr;
  cell_entry_t     cell_wr, cell_rd;
  logic [IAW-1:0]  info_addr;
  logic [15:0]     info_rd;

  logic            accept, out_free, push;
  out_item_t       push_item;
  logic [7:0]      code;
  logic [16:0]     idx;
  logic [15:0]     next_state;
  logic [CNTW-1:0] n_plus;
  logic [16:0]     info_p;
  logic            sym_in_alpha;

  tdr_alpha_map #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_alpha (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (alpha_ctl),
    .addr    (alpha_addr),
    .wr_code (in_data.load_value[7:0]),
    .rd_code (alpha_code)
  );

  tdr_cell_table #(.CELL_DEPTH(CELL_DEPTH)) u_cell (
    .clk      (clk),
    .ctl      (cell_ctl),
    .addr     (cell_addr),
    .wr_entry (cell_wr),
    .rd_entry (cell_rd)
  );

  tdr_info_store #(.INFO_DEPTH(INFO_DEPTH)) u_info (
    .clk     (clk),
    .ctl     (info_ctl),
    .addr    (info_addr),
    .wr_word (in_data.load_value),
    .rd_word (info_rd)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign sym_in_alpha = (CMP_W'(in_data.symbol) < ALPHA_LIM);
  assign alpha_addr   = in_data.symbol[ALW-1:0];
  assign cell_wr      = '{target: in_data.load_value, check: in_data.load_check};

  assign code       = code_ok_r ? alpha_code : 8'd0;
  assign idx        = {1'b0, cur_r} + {9'd0, code};
  assign next_state = (cell_rd.check == code_r) ? cell_rd.target : root_r;
  assign n_plus     = n_r + 1'b1;
  assign info_p     = {1'b0, base_r} + 17'(n_plus);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    hold_nxt      = hold_r;
    code_nxt      = code_r;
    code_ok_nxt   = code_ok_r;
    base_nxt      = base_r;
    n_nxt         = n_r;
    alpha_ctl     = '0;
    cell_ctl      = '0;
    info_ctl      = '0;
    cell_addr     = CAW'(in_data.load_address);
    info_addr     = IAW'(in_data.load_address);
    push          = 1'b0;
    push_item     = '{out_symbol: hold_r, last: 1'b1};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_SYMBOL: begin
              alpha_ctl.rd_en = sym_in_alpha;
              code_ok_nxt     = sym_in_alpha;
              hold_nxt        = in_data.symbol;
              state_nxt       = S_CODE;
            end
            KIND_ALPHA: begin
              alpha_ctl.wr_en = sym_in_alpha;
            end
            KIND_CELL: begin
              if (CMP_W'(in_data.load_address) < CELL_LIM) begin
                cell_ctl.wr_en = 1'b1;
                if (in_data.load_address == 16'd0) begin
                  root_nxt = in_data.load_value;
                  cur_nxt  = in_data.load_value;
                end
              end
            end
            KIND_INFO: begin
              info_ctl.wr_en = (CMP_W'(in_data.load_address) < INFO_LIM);
            end
            default: begin
            end
          endcase
        end
      end

      S_CODE: begin
        code_nxt = code;
        if (code != 8'd0 && CMP_W'(idx) < CELL_LIM) begin
          cell_ctl.rd_en = 1'b1;
          cell_addr      = CAW'(CMP_W'(idx));
          state_nxt      = S_STEP;
        end else begin
          // fall back to the root; the root itself is still tested for finality
          cur_nxt = root_r;
          if (CMP_W'(root_r) < CELL_LIM) begin
            cell_ctl.rd_en = 1'b1;
            cell_addr      = CAW'(CMP_W'(root_r));
            state_nxt      = S_FINAL;
          end else begin
            state_nxt = S_END;
          end
        end
      end

      S_STEP: begin
        cur_nxt = next_state;
        if (CMP_W'(next_state) < CELL_LIM) begin
          cell_ctl.rd_en = 1'b1;
          cell_addr      = CAW'(CMP_W'(next_state));
          state_nxt      = S_FINAL;
        end else begin
          state_nxt = S_END;
        end
      end

      S_FINAL: begin
        state_nxt = S_END;
        if (cell_rd.check == 8'd0) begin
          cur_nxt  = root_r;
          base_nxt = cell_rd.target;
          n_nxt    = '0;
          if (CMP_W'(cell_rd.target) < INFO_LIM) begin
            info_ctl.rd_en = 1'b1;
            info_addr      = IAW'(CMP_W'(cell_rd.target));
            state_nxt      = S_INFO;
          end
        end
      end

      S_INFO: begin
        if (info_rd == 16'd0) begin
          state_nxt = S_END;
        end else if (out_free) begin
          // a further word exists, so the held item is not the last one
          push      = 1'b1;
          push_item = '{out_symbol: hold_r, last: 1'b0};
          hold_nxt  = info_rd;
          n_nxt     = n_plus;
          if (n_plus < LEN_LIM && CMP_W'(info_p) < INFO_LIM) begin
            info_ctl.rd_en = 1'b1;
            info_addr      = IAW'(CMP_W'(info_p));
          end else begin
            state_nxt = S_END;
          end
        end
      end

      S_END: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= 16'd0;
      root_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hold_r     <= hold_nxt;
    code_r     <= code_nxt;
    code_ok_r  <= code_ok_nxt;
    base_r     <= base_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- design/tdr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdr_checker
// Port-level checks of the trie dictionary rewriter, bound to the top level.
// ----------------------------------------------------------------------------
module tdr_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire tdr_pkg::in_item_t in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire tdr_pkg::out_item_t out_data
);
  import tdr_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // a symbol item blocks input while its results are produced
  a_sym_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_SYMBOL |=> !in_ready)
    else $error("input taken during a symbol walk");

  // a load item returns no result and leaves input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind != KIND_SYMBOL |=> in_ready)
    else $error("load item closed the input");

  // input reopens only with the last result of the walk on show
  a_reopen_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_data.last)
    else $error("input reopened without a last result");

endmodule

bind trie_dictionary_rewriter_core tdr_checker u_tdr_checker (.*);
`default_nettype wire
